[sv/mnau_pkg.sv]
// ----------------------------------------------------------------------------
// mnau_pkg: shared types and codes of the microprogram next-address unit
// Holds the item and sequencer state types, the jump code prefixes
// and the flag mode codes.
// ----------------------------------------------------------------------------
package mnau_pkg;

  localparam int unsigned AddrW  = 9;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned JumpW  = 7;
  localparam int unsigned FlagCW = 4;
  localparam int unsigned PrioW  = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Jump kind prefixes, compared against the leading bits of the jump code.
  localparam logic [1:0] PFX_JCC = 2'b00;
  localparam logic [2:0] PFX_JZR = 3'b010;
  localparam logic [2:0] PFX_JCR = 3'b011;
  localparam logic [3:0] PFX_JCE = 4'b1110;
  localparam logic [2:0] PFX_JFL = 3'b100;
  localparam logic [3:0] PFX_JCF = 4'b1010;
  localparam logic [3:0] PFX_JZF = 4'b1011;
  localparam logic [3:0] PFX_JPR = 4'b1100;
  localparam logic [3:0] PFX_JLL = 4'b1101;
  localparam logic [4:0] PFX_JRL = 5'b11111;
  localparam logic [4:0] PFX_JPX = 5'b11110;

  // Input flag modes.
  localparam logic [1:0] FI_BOTH  = 2'b00;
  localparam logic [1:0] FI_ZERO  = 2'b01;
  localparam logic [1:0] FI_CARRY = 2'b10;
  localparam logic [1:0] FI_HOLD  = 2'b11;

  // Output flag modes.
  localparam logic [1:0] FO_LOW   = 2'b00;
  localparam logic [1:0] FO_CARRY = 2'b01;
  localparam logic [1:0] FO_ZERO  = 2'b10;
  localparam logic [1:0] FO_HIGH  = 2'b11;

  typedef struct packed {
    logic              action;
    logic [ByteW-1:0]  data_byte;
    logic [JumpW-1:0]  jump_code;
    logic [FlagCW-1:0] flag_code;
    logic              flag_in;
  } mnau_item_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    logic [PrioW-1:0] prio;
    logic             temp_flag;
    logic             carry;
    logic             zero;
    logic             out_flag;
  } mnau_state_t;

endpackage

[sv/mnau_if.sv]
// ----------------------------------------------------------------------------
// mnau_if: handshake channels of the microprogram next-address unit
// One interface carries input items, the other carries result items; a beat
// moves when valid and ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface mnau_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic [6:0] jump_code;
  logic [3:0] flag_code;
  logic       flag_in;

  modport source (output valid, action, data_byte, jump_code, flag_code, flag_in,
                  input ready);
  modport sink (input valid, action, data_byte, jump_code, flag_code, flag_in,
                output ready);
endinterface

interface mnau_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] micro_address;
  logic       flag_out;
  logic       carry_flag;
  logic       zero_flag;

  modport source (output valid, micro_address, flag_out, carry_flag, zero_flag,
                  input ready);
  modport sink (input valid, micro_address, flag_out, carry_flag, zero_flag,
                output ready);
endinterface

[sv/mnau_step.sv]
// ----------------------------------------------------------------------------
// mnau_step: next-state logic of the sequencer
// Applies one load or step item to the current state: latches, flag update,
// output flag selection and the jump kind decode that forms the next address.
// ----------------------------------------------------------------------------
module mnau_step
  import mnau_pkg::*;
(
  input  mnau_item_t  item_i,
  input  mnau_state_t state_i,
  output mnau_state_t state_o
);

  mnau_state_t      flg;
  logic [AddrW-1:0] a;
  logic [JumpW-1:0] x;
  logic [PrioW-1:0] p;

  always_comb begin
    flg = state_i;
    flg.prio = {1'b0, state_i.data[2:0]};
    flg.temp_flag = item_i.flag_in;
    case (item_i.flag_code[1:0])
      FI_BOTH: begin
        flg.carry = item_i.flag_in;
        flg.zero  = item_i.flag_in;
      end
      FI_ZERO:  flg.zero  = item_i.flag_in;
      FI_CARRY: flg.carry = item_i.flag_in;
      default: ;
    endcase
    case (item_i.flag_code[3:2])
      FO_LOW:   flg.out_flag = 1'b0;
      FO_CARRY: flg.out_flag = flg.carry;
      FO_ZERO:  flg.out_flag = flg.zero;
      default:  flg.out_flag = 1'b1;
    endcase
  end

  always_comb begin
    x = item_i.jump_code;
    p = flg.prio;
    a = state_i.addr;
    if (x[6:5] == PFX_JCC) begin
      a[8:4] = x[4:0];
    end else if (x[6:4] == PFX_JZR) begin
      a = {5'b0, x[3:0]};
    end else if (x[6:4] == PFX_JCR) begin
      a[3:0] = x[3:0];
    end else if (x[6:3] == PFX_JCE) begin
      a[6:4] = x[2:0];
    end else if (x[6:4] == PFX_JFL) begin
      a[7:4] = x[3:0];
      a[2:0] = {2'b01, flg.temp_flag};
    end else if (x[6:3] == PFX_JCF) begin
      a[6:4] = x[2:0];
      a[2:0] = {2'b01, flg.carry};
    end else if (x[6:3] == PFX_JZF) begin
      a[6:4] = x[2:0];
      a[2:0] = {2'b01, flg.zero};
    end else if (x[6:3] == PFX_JPR) begin
      a[6:4] = x[2:0];
      a[3:0] = p;
    end else if (x[6:3] == PFX_JLL) begin
      a[6:4] = x[2:0];
      a[3:0] = {2'b01, p[3], p[2]};
    end else if (x[6:2] == PFX_JRL) begin
      a[6:4] = x[2:0];
      a[3:0] = {2'b11, p[1], p[0]};
    end else begin
      // The remaining prefix is the JPX kind.
      a[5:4] = x[1:0];
      a[3:0] = state_i.data[7:4];
    end
  end

  always_comb begin
    state_o = state_i;
    if (item_i.action == ACT_LOAD) begin
      state_o.data = item_i.data_byte;
      state_o.addr = {1'b0, item_i.data_byte[3:0], item_i.data_byte[7:4]};
    end else begin
      state_o = flg;
      state_o.addr = a;
    end
  end

endmodule

[sv/microprogram_next_address_unit.sv]
// ----------------------------------------------------------------------------
// microprogram_next_address_unit: bit-slice style microprogram sequencer
// Each item passes the input register, then the result register, which offers
// its beat. Throughput: one beat per cycle while out_o.ready holds; the state
// update and jump decode sit between the two registers in a single pass.
// Reset: address, data latch, priority latch and all flags clear to zero, and
// both pipeline registers come up empty.
// ----------------------------------------------------------------------------
module microprogram_next_address_unit
  import mnau_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mnau_in_if.sink    in_i,
  mnau_out_if.source out_o
);

  logic        in_vld_q;
  mnau_item_t  item_q;
  mnau_state_t state_q, state_d;
  logic        out_vld_q;
  logic        advance;

  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  mnau_step u_step (
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= '{action:    in_i.action,
                  data_byte: in_i.data_byte,
                  jump_code: in_i.jump_code,
                  flag_code: in_i.flag_code,
                  flag_in:   in_i.flag_in};
    end
  end

  // The state register doubles as the result register: it is written exactly
  // when an item moves into the output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.micro_address = state_q.addr;
  assign out_o.flag_out      = state_q.out_flag;
  assign out_o.carry_flag    = state_q.carry;
  assign out_o.zero_flag     = state_q.zero;

endmodule
